/* rtl/core/mssd_pkg.sv */
// Shared types, constants and the segment decoder of the seven-segment display driver.
package mssd_pkg;

    // Number of multiplexed digits; only four digits are configured.
    localparam int unsigned NUM_DIGITS  = 4;
    localparam int unsigned DIGIT_COUNT = (NUM_DIGITS > 4) ? 4 : ((NUM_DIGITS < 1) ? 1 : NUM_DIGITS);
    localparam logic [1:0]  LAST_DIGIT  = 2'(DIGIT_COUNT - 1);

    // Brightness slots inside the packed brightness register.
    localparam logic [2:0] SLOT_INDICATORS = 3'd4;
    localparam logic [2:0] SLOT_RING       = 3'd5;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_DIGIT_CODES       = 3'd0,
        REG_RAW_PATTERNS      = 3'd1,
        REG_INDIVIDUAL_MODE   = 3'd2,
        REG_BRIGHTNESS_LEVELS = 3'd3,
        REG_INDICATOR_ENABLES = 3'd4,
        REG_DWELL_TICKS       = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] digit_codes;
        logic [27:0] raw_patterns;
        logic        individual_mode;
        logic [35:0] brightness_levels;
        logic [2:0]  indicator_enables;
        logic [7:0]  dwell_ticks;
    } cfg_regs_t;

    // Display state; indicator bits are PM light, colon, alarm LED from bit 0.
    typedef struct packed {
        logic [7:0] dwell_count;
        logic [7:0] pwm_level;
        logic [1:0] current_digit;
        logic [6:0] segment_store;
        logic [3:0] anode_store;
        logic [2:0] indicator_store;
    } disp_state_t;

    typedef struct packed {
        logic tick;
    } tick_item_t;

    typedef struct packed {
        logic [6:0] seg_out;
        logic [3:0] anode_out;
        logic       pm_light;
        logic       colon_light;
        logic       alarm_light;
        logic [1:0] shown_digit;
    } result_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [35:0] data;
    } cfg_write_t;

    // Segment pattern for a display code: digits, then 'o', 'n', 'f', then blank.
    function automatic logic [6:0] seg_decode(input logic [3:0] code);
        logic [6:0] pattern;
        case (code)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            4'd10:   pattern = 7'h5C;
            4'd11:   pattern = 7'h54;
            4'd12:   pattern = 7'h71;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

    // One 6-bit brightness level out of the packed register.
    function automatic logic [5:0] level_of(input logic [35:0] levels, input logic [2:0] slot);
        return levels[6 * slot +: 6];
    endfunction

endpackage

/* rtl/core/mssd_if.sv */
// Handshake interfaces for the tick, result and configuration channels.
interface mssd_tick_if;
    import mssd_pkg::*;
    logic       valid;
    logic       ready;
    tick_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mssd_result_if;
    import mssd_pkg::*;
    logic         valid;
    logic         ready;
    result_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mssd_cfg_if;
    import mssd_pkg::*;
    logic       valid;
    logic       ready;
    cfg_write_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/mssd_next.sv */
// Next-state logic of the display multiplexer and PWM dimmer for one tick.
module mssd_next (
    input  mssd_pkg::cfg_regs_t   cfg_regs,
    input  mssd_pkg::disp_state_t cur,
    input  logic                  tick,
    output mssd_pkg::disp_state_t nxt
);
    import mssd_pkg::*;

    logic [7:0] count_inc;
    logic       advance;
    logic [1:0] digit_adv;
    logic [5:0] level_ind;
    logic [5:0] level_ring;
    logic [5:0] level_adv;
    logic [5:0] level_cur;
    logic [6:0] pattern_adv;

    assign count_inc  = cur.dwell_count + 8'd1;
    assign advance    = (count_inc >= cfg_regs.dwell_ticks);
    assign digit_adv  = (cur.current_digit >= LAST_DIGIT) ? 2'd0 : cur.current_digit + 2'd1;
    assign level_ind  = level_of(cfg_regs.brightness_levels, SLOT_INDICATORS);
    assign level_ring = level_of(cfg_regs.brightness_levels, SLOT_RING);
    assign level_adv  = level_of(cfg_regs.brightness_levels, {1'b0, digit_adv});
    assign level_cur  = advance ? level_adv
                                : level_of(cfg_regs.brightness_levels, {1'b0, cur.current_digit});

    // Pattern of the digit that comes up next, raw or decoded.
    assign pattern_adv = cfg_regs.individual_mode
                       ? cfg_regs.raw_patterns[7 * digit_adv +: 7]
                       : seg_decode(cfg_regs.digit_codes[4 * digit_adv +: 4]);

    // Digit switch at the end of the dwell, then PWM dimming and level count.
    always_comb
    begin
        nxt = cur;
        if (tick)
        begin
            nxt.dwell_count = count_inc;
            if (advance)
            begin
                nxt.dwell_count   = 8'd0;
                nxt.pwm_level     = 8'd0;
                nxt.current_digit = digit_adv;
                nxt.indicator_store = {(level_ring != 6'd0) & cfg_regs.indicator_enables[2],
                                       {2{level_ind != 6'd0}} & cfg_regs.indicator_enables[1:0]};
                if (level_adv == 6'd0)
                begin
                    nxt.segment_store = 7'd0;
                    nxt.anode_store   = 4'd0;
                end
                else
                begin
                    nxt.segment_store = pattern_adv;
                    nxt.anode_store   = 4'd1 << digit_adv;
                end
            end
            if (nxt.pwm_level >= {2'b00, level_cur})
            begin
                nxt.segment_store = 7'd0;
            end
            if (nxt.pwm_level >= {2'b00, level_ind})
            begin
                nxt.indicator_store[1:0] = 2'b00;
            end
            if (nxt.pwm_level >= {2'b00, level_ring})
            begin
                nxt.indicator_store[2] = 1'b0;
            end
            nxt.pwm_level = nxt.pwm_level + 8'd1;
        end
    end

endmodule

/* rtl/core/mux_seven_segment_pwm_driver.sv */
// Top level of the multiplexed seven-segment display driver with PWM dimming.
//
// Usage:
//   timer   - sink of tick items; each transfer with tick set advances the
//             dwell and PWM counters, a transfer with tick clear changes nothing.
//   display - source of result items: segments, one-hot anodes, PM light,
//             colon, alarm LED and the index of the digit being shown.
//   cfg     - register writes (index, data); always ready, one write per cycle.
//             Writes to an index past the last register are ignored.
// Every accepted tick item produces exactly one result item in the next cycle
// from the result register. One tick item is taken every cycle unless the
// receiver stalls; the state update is one pass through the next-state logic
// into the state registers. When the receiver stalls, the result register
// holds its item and the timer channel drops ready until that item is transferred.
// Reset clears the counters, the digit index and all lights, loads the
// configuration registers with their defaults and empties the result register.
module mux_seven_segment_pwm_driver (
    input logic          clk,
    input logic          rst_n,
    mssd_tick_if.sink    timer,
    mssd_result_if.source display,
    mssd_cfg_if.sink     cfg
);
    import mssd_pkg::*;

    cfg_regs_t    cfg_reg;
    disp_state_t  state_reg;
    disp_state_t  state_next;
    logic         out_valid_reg;
    result_item_t out_item_reg;
    logic         tick_xfer;
    logic         out_xfer;

    assign timer.ready = !out_valid_reg || display.ready;
    assign tick_xfer   = timer.valid && timer.ready;
    assign out_xfer    = out_valid_reg && display.ready;
    assign cfg.ready   = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digit_codes       <= 16'd17185;
            cfg_reg.raw_patterns      <= 28'hFFFFFFF;
            cfg_reg.individual_mode   <= 1'b0;
            cfg_reg.brightness_levels <= 36'd34905131040;
            cfg_reg.indicator_enables <= 3'd6;
            cfg_reg.dwell_ticks       <= 8'd32;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_DIGIT_CODES:       cfg_reg.digit_codes       <= cfg.payload.data[15:0];
                REG_RAW_PATTERNS:      cfg_reg.raw_patterns      <= cfg.payload.data[27:0];
                REG_INDIVIDUAL_MODE:   cfg_reg.individual_mode   <= cfg.payload.data[0];
                REG_BRIGHTNESS_LEVELS: cfg_reg.brightness_levels <= cfg.payload.data;
                REG_INDICATOR_ENABLES: cfg_reg.indicator_enables <= cfg.payload.data[2:0];
                REG_DWELL_TICKS:       cfg_reg.dwell_ticks       <= cfg.payload.data[7:0];
                default:               ;
            endcase
        end
    end

    mssd_next u_next (
        .cfg_regs (cfg_reg),
        .cur      (state_reg),
        .tick     (timer.payload.tick),
        .nxt      (state_next)
    );

    // Display state advances on each tick transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (tick_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded from the updated state.
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            out_item_reg.seg_out     <= state_next.segment_store;
            out_item_reg.anode_out   <= state_next.anode_store;
            out_item_reg.pm_light    <= state_next.indicator_store[0];
            out_item_reg.colon_light <= state_next.indicator_store[1];
            out_item_reg.alarm_light <= state_next.indicator_store[2];
            out_item_reg.shown_digit <= state_next.current_digit;
        end
    end

    assign display.valid   = out_valid_reg;
    assign display.payload = out_item_reg;

    // At most one digit is powered at a time.
    a_anode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(state_reg.anode_store))
        else $error("more than one anode driven");

    // A powered anode always belongs to the digit being shown.
    a_anode_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.anode_store != 4'd0) |->
            (state_reg.anode_store == (4'd1 << state_reg.current_digit)))
        else $error("anode does not match the shown digit");

    // Every tick transfer leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> out_valid_reg)
        else $error("tick transfer produced no result");

    // Without a tick transfer the display state does not move.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_xfer |=> $stable(state_reg))
        else $error("display state changed without a tick");

    // The shown digit in a result matches the state it came from.
    a_result_digit: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> (out_item_reg.shown_digit == state_reg.current_digit))
        else $error("result digit differs from state");

endmodule

/* tb/sv/testbench.sv */
// Testbench of the seven-segment display driver: random ticks and settings against a predictor.
module testbench;
    import mssd_pkg::*;

    localparam int          HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES   = 5;
    localparam int          IDLE_PERCENT   = 22;
    localparam int          TICK_PERCENT   = 85;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          DRAIN_CYCLES   = 4;
    localparam longint      CYCLE_LIMIT    = 400000;
    localparam int          RANDOM_PHASES  = 12;
    localparam int          PHASE_ITEMS    = 130;
    localparam int          LONG_ITEMS     = 600;
    localparam logic [2:0]  REG_SPARE_LO   = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI   = 3'd7;
    localparam logic [35:0] ALL_ONES       = '1;

    // Segment patterns by display code: digits, 'o', 'n', 'f', then blank.
    localparam logic [6:0] GLYPHS [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h5C, 7'h54, 7'h71, 7'h00, 7'h00, 7'h00
    };

    logic clk;
    logic rst_n;

    mssd_tick_if   timer_ch ();
    mssd_result_if display_ch ();
    mssd_cfg_if    cfg_ch ();

    mux_seven_segment_pwm_driver i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .timer   (timer_ch),
        .display (display_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state: a private copy of the registers and of the display state.
    cfg_regs_t    shadow_regs;
    disp_state_t  shadow_disp;
    result_item_t expected_frames[$];
    tick_item_t   pending_ticks[$];

    int     fail_count;
    bit     steady_flow;
    int     holdoff_left;
    logic   tick_xfer;
    longint cycle_count;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Cycle limit guards against a hung handshake.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[mux_seven_segment_pwm_driver] ERROR");
            $finish;
        end
    end

    // Brightness of one slot: digits 0-3, then indicators, then the ring LED.
    function automatic logic [5:0] slot_brightness(input int slot);
        return shadow_regs.brightness_levels[6 * slot +: 6];
    endfunction

    // Register write as the block sees it, truncated to each register's width.
    function automatic void shadow_write(input logic [2:0] idx, input logic [35:0] data);
        case (idx)
            REG_DIGIT_CODES:       shadow_regs.digit_codes       = data[15:0];
            REG_RAW_PATTERNS:      shadow_regs.raw_patterns      = data[27:0];
            REG_INDIVIDUAL_MODE:   shadow_regs.individual_mode   = data[0];
            REG_BRIGHTNESS_LEVELS: shadow_regs.brightness_levels = data[35:0];
            REG_INDICATOR_ENABLES: shadow_regs.indicator_enables = data[2:0];
            REG_DWELL_TICKS:       shadow_regs.dwell_ticks       = data[7:0];
            default: ;
        endcase
    endfunction

    // Advance the display by one tick item and queue the frame it produces.
    function automatic void advance_display(input logic tick);
        logic [1:0]   d;
        result_item_t frame;
        if (tick)
        begin
            shadow_disp.dwell_count = shadow_disp.dwell_count + 8'd1;
            // Dwell expired: restart the counters and switch to the next digit.
            if (shadow_disp.dwell_count >= shadow_regs.dwell_ticks)
            begin
                shadow_disp.dwell_count = '0;
                shadow_disp.pwm_level   = '0;
                shadow_disp.indicator_store = '0;
                if (slot_brightness(SLOT_INDICATORS) != 0)
                    shadow_disp.indicator_store = {1'b0, shadow_regs.indicator_enables[1:0]};
                if (slot_brightness(SLOT_RING) != 0)
                    shadow_disp.indicator_store[2] = shadow_regs.indicator_enables[2];
                if (shadow_disp.current_digit >= LAST_DIGIT)
                    shadow_disp.current_digit = '0;
                else
                    shadow_disp.current_digit = shadow_disp.current_digit + 2'd1;
                d = shadow_disp.current_digit;
                shadow_disp.anode_store = '0;
                if (shadow_regs.individual_mode)
                    shadow_disp.segment_store = shadow_regs.raw_patterns[7 * d +: 7];
                else
                    shadow_disp.segment_store = GLYPHS[shadow_regs.digit_codes[4 * d +: 4]];
                if (slot_brightness(d) == 0)
                    shadow_disp.segment_store = '0;
                else
                    shadow_disp.anode_store = 4'b0001 << d;
            end
            // Dimming: each light goes dark once the PWM level reaches its brightness.
            d = shadow_disp.current_digit;
            if (shadow_disp.pwm_level >= slot_brightness(d))
                shadow_disp.segment_store = '0;
            if (shadow_disp.pwm_level >= slot_brightness(SLOT_INDICATORS))
                shadow_disp.indicator_store &= 3'b100;
            if (shadow_disp.pwm_level >= slot_brightness(SLOT_RING))
                shadow_disp.indicator_store &= 3'b011;
            shadow_disp.pwm_level = shadow_disp.pwm_level + 8'd1;
        end
        frame.seg_out     = shadow_disp.segment_store;
        frame.anode_out   = shadow_disp.anode_store;
        frame.pm_light    = shadow_disp.indicator_store[0];
        frame.colon_light = shadow_disp.indicator_store[1];
        frame.alarm_light = shadow_disp.indicator_store[2];
        frame.shown_digit = shadow_disp.current_digit;
        expected_frames.push_back(frame);
    endfunction

    function automatic void check_field(input string name, input logic [6:0] want,
                                        input logic [6:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: check each frame transfer, then predict from each tick transfer.
    always @(posedge clk)
    begin : frame_monitor
        result_item_t want;
        result_item_t got;
        tick_xfer = rst_n && timer_ch.valid && timer_ch.ready;
        if (rst_n && display_ch.valid && display_ch.ready)
        begin
            got = display_ch.payload;
            if (expected_frames.size() == 0)
            begin
                $error("unexpected frame transfer: %0h", got);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                check_field("seg_out", want.seg_out, got.seg_out);
                check_field("anode_out", 7'(want.anode_out), 7'(got.anode_out));
                check_field("pm_light", 7'(want.pm_light), 7'(got.pm_light));
                check_field("colon_light", 7'(want.colon_light), 7'(got.colon_light));
                check_field("alarm_light", 7'(want.alarm_light), 7'(got.alarm_light));
                check_field("shown_digit", 7'(want.shown_digit), 7'(got.shown_digit));
            end
        end
        if (tick_xfer)
            advance_display(timer_ch.payload.tick);
    end

    // Tick driver: offers queued items with random gaps.
    always @(negedge clk)
    begin : tick_driver
        logic       next_valid;
        tick_item_t next_item;
        next_valid = timer_ch.valid;
        next_item  = timer_ch.payload;
        if (!timer_ch.valid || tick_xfer)
        begin
            if (pending_ticks.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
            begin
                next_valid = 1'b1;
                next_item  = pending_ticks.pop_front();
            end
            else
            begin
                next_valid     = 1'b0;
                next_item.tick = 1'($urandom_range(1));
            end
        end
        timer_ch.valid   <= next_valid;
        timer_ch.payload <= next_item;
    end

    // Frame receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            display_ch.ready <= 1'b0;
            holdoff_left--;
        end
        else
        begin
            display_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [35:0] data);
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.payload.index <= idx;
        cfg_ch.payload.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        shadow_write(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_ticks(input int count);
        tick_item_t item;
        for (int n = 0; n < count; n++)
        begin
            item.tick = ($urandom_range(99) < TICK_PERCENT);
            pending_ticks.push_back(item);
        end
    endtask

    // Wait until every item is taken and every frame is back, then let the pipe drain.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_ticks.size() != 0 || timer_ch.valid || expected_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random brightness word with zero, full and dim levels well represented.
    function automatic logic [35:0] pick_levels();
        logic [35:0] levels;
        for (int s = 0; s < 6; s++)
        begin
            case ($urandom_range(4))
                0:       levels[6 * s +: 6] = 6'd0;
                1:       levels[6 * s +: 6] = 6'd63;
                2:       levels[6 * s +: 6] = 6'($urandom_range(1, 3));
                default: levels[6 * s +: 6] = 6'($urandom);
            endcase
        end
        return levels;
    endfunction

    function automatic logic [7:0] pick_dwell();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 8'($urandom_range(0, 4));
            5, 6, 7:       return 8'($urandom_range(5, 40));
            default:       return 8'($urandom);
        endcase
    endfunction

    // Main sequence: reset, directed phases, then random phases.
    initial
    begin : stimulus
        tick_item_t item;
        int         count;
        fail_count         = 0;
        steady_flow        = 1'b0;
        holdoff_left       = 0;
        tick_xfer          = 1'b0;
        timer_ch.valid     = 1'b0;
        timer_ch.payload   = '0;
        display_ch.ready   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.payload     = '0;
        shadow_regs        = '{16'd17185, 28'hFFFFFFF, 1'b0, 36'd34905131040, 3'd6, 8'd32};
        shadow_disp        = '0;
        rst_n              = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: idle ticks repeat the dark frame, live ticks count.
        for (int n = 0; n < 6; n++)
        begin
            item.tick = (n >= 3);
            pending_ticks.push_back(item);
        end
        wait_idle();

        // Zero dwell switches every tick; digit 2 has zero brightness and stays dark.
        write_reg(REG_DWELL_TICKS, 36'd0);
        write_reg(REG_BRIGHTNESS_LEVELS, {6'd63, 6'd1, 6'd63, 6'd0, 6'd63, 6'd63});
        write_reg(REG_INDICATOR_ENABLES, 36'd7);
        write_reg(REG_DIGIT_CODES, 36'h0000FCBA);
        for (int n = 0; n < 10; n++)
        begin
            item.tick = (n != 4);
            pending_ticks.push_back(item);
        end
        wait_idle();

        // Raw patterns dimmed during the dwell; writes to spare indexes do nothing.
        write_reg(REG_SPARE_LO, ALL_ONES);
        write_reg(REG_SPARE_HI, 36'd0);
        write_reg(REG_INDIVIDUAL_MODE, 36'd1);
        write_reg(REG_RAW_PATTERNS, 36'h00FC07F);
        write_reg(REG_DWELL_TICKS, 36'd2);
        write_reg(REG_BRIGHTNESS_LEVELS, {6{6'd1}});
        for (int n = 0; n < 8; n++)
        begin
            item.tick = 1'b1;
            pending_ticks.push_back(item);
        end
        wait_idle();

        // Random phases; the first two hold every register at its extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(REG_DIGIT_CODES, ALL_ONES);
                write_reg(REG_RAW_PATTERNS, ALL_ONES);
                write_reg(REG_INDIVIDUAL_MODE, ALL_ONES);
                write_reg(REG_BRIGHTNESS_LEVELS, ALL_ONES);
                write_reg(REG_INDICATOR_ENABLES, ALL_ONES);
                write_reg(REG_DWELL_TICKS, 36'd255);
            end
            else if (phase == 1)
            begin
                write_reg(REG_DIGIT_CODES, 36'd0);
                write_reg(REG_RAW_PATTERNS, 36'd0);
                write_reg(REG_INDIVIDUAL_MODE, 36'd0);
                write_reg(REG_BRIGHTNESS_LEVELS, 36'd0);
                write_reg(REG_INDICATOR_ENABLES, 36'd0);
                write_reg(REG_DWELL_TICKS, 36'd0);
            end
            else
            begin
                write_reg(REG_DIGIT_CODES, 36'({$urandom, $urandom}));
                write_reg(REG_RAW_PATTERNS, 36'({$urandom, $urandom}));
                write_reg(REG_INDIVIDUAL_MODE, 36'({$urandom, $urandom}));
                write_reg(REG_BRIGHTNESS_LEVELS, pick_levels());
                write_reg(REG_INDICATOR_ENABLES, 36'({$urandom, $urandom}));
                write_reg(REG_DWELL_TICKS, {28'($urandom), pick_dwell()});
                if ($urandom_range(3) == 0)
                    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                              36'({$urandom, $urandom}));
            end
            count = (phase == 0) ? LONG_ITEMS : PHASE_ITEMS;
            // One phase runs with no idling on either side.
            steady_flow = (phase == 3);
            push_ticks(count);
            // In another the receiver stalls long enough for the input to back up.
            if (phase == 6)
            begin
                @(posedge clk);
                holdoff_left = HOLDOFF_CYCLES;
            end
            wait_idle();
            steady_flow = 1'b0;
        end

        if (fail_count == 0 && expected_frames.size() == 0)
            $display("[mux_seven_segment_pwm_driver] OK");
        else
            $display("[mux_seven_segment_pwm_driver] ERROR");
        $finish;
    end

endmodule
